// ===== rtl/grid_maze_reachability_defines.svh =====
// Assertion macros shared by the grid maze reachability RTL
`ifndef GRID_MAZE_REACHABILITY_DEFINES_SVH
`define GRID_MAZE_REACHABILITY_DEFINES_SVH
`ifndef SYNTH
`define GMR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gmr: same-cycle check failed");
`define GMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gmr: next-cycle check failed");
`else
`define GMR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define GMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/gmr_pkg.sv =====
// Types and constants shared by the grid maze reachability modules
`default_nettype none

package gmr_pkg;

  localparam int COORD_W   = 5;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     DIM_RESET    = 6'd1;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_DOWN,
    DIR_RIGHT,
    DIR_UP
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_NBR,
    ST_CHECK,
    ST_POP,
    ST_POPW,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               we;
    logic               start;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               cell_open;
  } load_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic reachable;
  } srch_sts_t;

  function automatic dir_e next_dir(dir_e d);
    dir_e n;
    case (d)
      DIR_LEFT:  n = DIR_DOWN;
      DIR_DOWN:  n = DIR_RIGHT;
      DIR_RIGHT: n = DIR_UP;
      default:   n = DIR_LEFT;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gmr_nbr_unit.sv =====
// Shared step unit: one increment or decrement and one bound compare per neighbour
`default_nettype none

module gmr_nbr_unit #(
  parameter int DIM_W = 5
) (
  input  wire logic [DIM_W-1:0] cur_r_i,
  input  wire logic [DIM_W-1:0] cur_c_i,
  input  gmr_pkg::dir_e         dir_i,
  input  wire logic [DIM_W-1:0] last_r_i,
  input  wire logic [DIM_W-1:0] last_c_i,
  output logic      [DIM_W-1:0] nbr_r_o,
  output logic      [DIM_W-1:0] nbr_c_o,
  output logic                  ok_o
);

  logic             use_col;
  logic             dec;
  logic [DIM_W-1:0] opnd;
  logic [DIM_W-1:0] bound;
  logic [DIM_W-1:0] sum;

  always_comb begin
    use_col = (dir_i == gmr_pkg::DIR_LEFT) || (dir_i == gmr_pkg::DIR_RIGHT);
    dec     = (dir_i == gmr_pkg::DIR_LEFT) || (dir_i == gmr_pkg::DIR_UP);
    opnd    = use_col ? cur_c_i : cur_r_i;
    // moving down or right stops at the last row or column, else at zero
    bound   = dec ? '0 : (use_col ? last_c_i : last_r_i);
    sum     = dec ? (opnd - DIM_W'(1)) : (opnd + DIM_W'(1));
    ok_o    = (opnd != bound);
    nbr_r_o = use_col ? cur_r_i : sum;
    nbr_c_o = use_col ? sum : cur_c_i;
  end

endmodule

`default_nettype wire

// ===== rtl/gmr_search.sv =====
// Maze store and depth-first search sequencer around the shared step unit
`default_nettype none
`include "grid_maze_reachability_defines.svh"

module gmr_search #(
  parameter int MAX_DIM = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  gmr_pkg::load_req_t             req_i,
  input  wire logic [gmr_pkg::CFG_W-1:0] num_rows_i,
  input  wire logic [gmr_pkg::CFG_W-1:0] num_cols_i,
  input  wire logic                      done_ack_i,
  output gmr_pkg::srch_sts_t             sts_o
);

  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int CELL_W = 2 * DIM_W;
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int SP_W   = $clog2(CELLS + 1);
  localparam int DV_W   = $clog2(MAX_DIM + 1);
  localparam int VROW_W = 2 ** DIM_W;
  localparam int MAP_D  = 2 ** CELL_W;
  localparam int EXT_W  = gmr_pkg::CFG_W + 1;

  logic              open_mem [MAP_D];
  logic [VROW_W-1:0] vis_mem  [VROW_W];
  logic [CELL_W-1:0] stk_mem  [CELLS];

  gmr_pkg::state_e st_q, st_d;
  gmr_pkg::dir_e   dir_q, dir_d;
  logic [DIM_W-1:0] cur_r_q, cur_r_d, cur_c_q, cur_c_d;
  logic [DIM_W-1:0] cand_r_q, cand_r_d, cand_c_q, cand_c_d;
  logic [DIM_W-1:0] clr_q, clr_d;
  logic [SP_W-1:0]  sp_q, sp_d, sp_m1;
  logic             reach_q, reach_d;

  logic              open_rd_q;
  logic [VROW_W-1:0] vis_rd_q;
  logic [CELL_W-1:0] stk_rd_q;

  logic [DV_W-1:0]   rows_c, cols_c;
  logic [DIM_W-1:0]  last_r, last_c;
  logic [DIM_W-1:0]  nbr_r, nbr_c;
  logic              nbr_ok;
  logic [DIM_W-1:0]  rd_r, rd_c;
  logic              vis_we;
  logic [DIM_W-1:0]  vis_wa;
  logic [VROW_W-1:0] vis_wd;
  logic              stk_we;
  logic              load_ok;
  logic [EXT_W-1:0]  ld_r_ext, ld_c_ext;

  // saturate the configured size to the storage
  always_comb begin
    rows_c = (EXT_W'(num_rows_i) > EXT_W'(MAX_DIM)) ? DV_W'(MAX_DIM) : DV_W'(num_rows_i);
    cols_c = (EXT_W'(num_cols_i) > EXT_W'(MAX_DIM)) ? DV_W'(MAX_DIM) : DV_W'(num_cols_i);
    last_r = DIM_W'(rows_c - DV_W'(1));
    last_c = DIM_W'(cols_c - DV_W'(1));
    ld_r_ext = EXT_W'(req_i.row);
    ld_c_ext = EXT_W'(req_i.col);
    load_ok  = req_i.we && (ld_r_ext < EXT_W'(MAX_DIM)) && (ld_c_ext < EXT_W'(MAX_DIM));
    sp_m1    = sp_q - SP_W'(1);
  end

  gmr_nbr_unit #(
    .DIM_W (DIM_W)
  ) u_nbr (
    .cur_r_i  (cur_r_q),
    .cur_c_i  (cur_c_q),
    .dir_i    (dir_q),
    .last_r_i (last_r),
    .last_c_i (last_c),
    .nbr_r_o  (nbr_r),
    .nbr_c_o  (nbr_c),
    .ok_o     (nbr_ok)
  );

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      open_mem[{ld_r_ext[DIM_W-1:0], ld_c_ext[DIM_W-1:0]}] <= req_i.cell_open;
    end
    open_rd_q <= open_mem[{rd_r, rd_c}];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_q <= vis_mem[rd_r];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[sp_q[IDX_W-1:0]] <= {cand_r_q, cand_c_q};
    end
    stk_rd_q <= stk_mem[sp_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= gmr_pkg::ST_IDLE;
      sp_q    <= '0;
      reach_q <= 1'b0;
      dir_q   <= gmr_pkg::DIR_LEFT;
    end else begin
      st_q    <= st_d;
      sp_q    <= sp_d;
      reach_q <= reach_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_r_q  <= cur_r_d;
    cur_c_q  <= cur_c_d;
    cand_r_q <= cand_r_d;
    cand_c_q <= cand_c_d;
    clr_q    <= clr_d;
  end

  always_comb begin
    st_d     = st_q;
    dir_d    = dir_q;
    cur_r_d  = cur_r_q;
    cur_c_d  = cur_c_q;
    cand_r_d = cand_r_q;
    cand_c_d = cand_c_q;
    clr_d    = clr_q;
    sp_d     = sp_q;
    reach_d  = reach_q;
    rd_r     = nbr_r;
    rd_c     = nbr_c;
    vis_we   = 1'b0;
    vis_wa   = cand_r_q;
    vis_wd   = vis_rd_q | (VROW_W'(1) << cand_c_q);
    stk_we   = 1'b0;
    case (st_q)
      gmr_pkg::ST_IDLE: begin
        if (req_i.start) begin
          sp_d  = '0;
          clr_d = '0;
          if ((rows_c == '0) || (cols_c == '0)) begin
            reach_d = 1'b0;
            st_d    = gmr_pkg::ST_DONE;
          end else begin
            st_d = gmr_pkg::ST_CLEAR;
          end
        end
      end
      gmr_pkg::ST_CLEAR: begin
        // wipe one visited row per cycle, only rows in use
        vis_we = 1'b1;
        vis_wa = clr_q;
        vis_wd = '0;
        if (clr_q == last_r) begin
          st_d = gmr_pkg::ST_SEED;
        end else begin
          clr_d = clr_q + DIM_W'(1);
        end
      end
      gmr_pkg::ST_SEED: begin
        rd_r     = '0;
        rd_c     = '0;
        cand_r_d = '0;
        cand_c_d = '0;
        // the start cell is a lone candidate, so pop right after it
        dir_d    = gmr_pkg::DIR_UP;
        st_d     = gmr_pkg::ST_CHECK;
      end
      gmr_pkg::ST_NBR: begin
        if (nbr_ok) begin
          cand_r_d = nbr_r;
          cand_c_d = nbr_c;
          st_d     = gmr_pkg::ST_CHECK;
        end else if (dir_q == gmr_pkg::DIR_UP) begin
          st_d = gmr_pkg::ST_POP;
        end else begin
          dir_d = gmr_pkg::next_dir(dir_q);
        end
      end
      gmr_pkg::ST_CHECK: begin
        if (open_rd_q && !vis_rd_q[cand_c_q]) begin
          vis_we = 1'b1;
          stk_we = 1'b1;
          sp_d   = sp_q + SP_W'(1);
        end
        if (dir_q == gmr_pkg::DIR_UP) begin
          st_d = gmr_pkg::ST_POP;
        end else begin
          dir_d = gmr_pkg::next_dir(dir_q);
          st_d  = gmr_pkg::ST_NBR;
        end
      end
      gmr_pkg::ST_POP: begin
        if (sp_q == '0) begin
          reach_d = 1'b0;
          st_d    = gmr_pkg::ST_DONE;
        end else begin
          sp_d = sp_m1;
          st_d = gmr_pkg::ST_POPW;
        end
      end
      gmr_pkg::ST_POPW: begin
        cur_r_d = stk_rd_q[CELL_W-1:DIM_W];
        cur_c_d = stk_rd_q[DIM_W-1:0];
        if (stk_rd_q == {last_r, last_c}) begin
          reach_d = 1'b1;
          st_d    = gmr_pkg::ST_DONE;
        end else begin
          dir_d = gmr_pkg::DIR_LEFT;
          st_d  = gmr_pkg::ST_NBR;
        end
      end
      gmr_pkg::ST_DONE: begin
        if (done_ack_i) begin
          st_d = gmr_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = gmr_pkg::ST_IDLE;
      end
    endcase
  end

  assign sts_o.idle      = (st_q == gmr_pkg::ST_IDLE);
  assign sts_o.done      = (st_q == gmr_pkg::ST_DONE);
  assign sts_o.reachable = reach_q;

  `GMR_ASSERT_IMPL(a_check_follows_read, clk_i, rst_ni, st_q == gmr_pkg::ST_CHECK, $past(st_q) == gmr_pkg::ST_SEED || $past(st_q) == gmr_pkg::ST_NBR)
  `GMR_ASSERT_IMPL(a_stack_room, clk_i, rst_ni, stk_we, sp_q < SP_W'(CELLS))
  `GMR_ASSERT_IMPL(a_clear_empty_stack, clk_i, rst_ni, st_q == gmr_pkg::ST_CLEAR, sp_q == '0)
  `GMR_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, st_q == gmr_pkg::ST_IDLE && req_i.start, st_q == gmr_pkg::ST_CLEAR || st_q == gmr_pkg::ST_DONE)

endmodule

`default_nettype wire

// ===== rtl/grid_maze_reachability.sv =====
// Top level of the grid maze reachability block: stream ports, size registers, result register
//
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+------------------------------------------
//  s_axis    | in  | tvalid / tready         | tdata: row, col, cell_open; tlast: run_search
//  m_axis    | out | tvalid / tready         | tdata: reachable
//  cfg       | in  | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i (num_rows, num_cols)
//
// A cell without tlast is just stored; s_axis_tready stays high between searches.
// A transfer with tlast stores the cell, then the search sequencer runs: it wipes the
// visited rows in use, then for each reachable cell pops it, takes the stack entry and
// reads and checks each of four neighbours through the one step unit and the maze, visited
// and stack memories, each one-read one-write. s_axis_tready is low during the search.
// The result waits in an output register; loading the next maze goes on meanwhile, and a
// finished search holds until that register is free. Reset sets both sizes to one.
`default_nettype none
`include "grid_maze_reachability_defines.svh"

module grid_maze_reachability #(
  parameter int MAX_DIM = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // row[4:0], col[9:5], cell_open[10]
  input  wire logic                          s_axis_tlast,  // run_search
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [7:0]                    m_axis_tdata,  // reachable[0]
  input  wire logic                          cfg_we_i,
  input  wire logic [gmr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gmr_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [gmr_pkg::CFG_W-1:0] num_rows_q, num_cols_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_data_q, out_data_d;
  logic                      in_xfer;
  logic                      done_ack;
  gmr_pkg::load_req_t        req;
  gmr_pkg::srch_sts_t        sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= gmr_pkg::DIM_RESET;
      num_cols_q <= gmr_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gmr_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        gmr_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = sts.idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req.we        = in_xfer;
    req.start     = in_xfer && s_axis_tlast;
    req.row       = s_axis_tdata[4:0];
    req.col       = s_axis_tdata[9:5];
    req.cell_open = s_axis_tdata[10];
  end

  gmr_search #(
    .MAX_DIM (MAX_DIM)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .num_rows_i (num_rows_q),
    .num_cols_i (num_cols_q),
    .done_ack_i (done_ack),
    .sts_o      (sts)
  );

  // hand the result over only when the output register is free or draining
  assign done_ack = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (sts.done && done_ack) begin
      out_valid_d = 1'b1;
      out_data_d  = sts.reachable;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_data_q};

  `GMR_ASSERT_NEXT(a_done_held_while_full, clk_i, rst_ni, sts.done && out_valid_q && !m_axis_tready, sts.done)
  `GMR_ASSERT_IMPL(a_no_load_while_busy, clk_i, rst_ni, in_xfer, !sts.done)
  `GMR_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, sts.done && done_ack, out_valid_q)

endmodule

`default_nettype wire

// ===== test/grid_maze_reachability_test.sv =====
// Self-checking testbench of grid_maze_reachability: streamed mazes checked by a path search
`timescale 1ns / 1ps

module grid_maze_reachability_test;
  import gmr_pkg::*;

  localparam int MAX_DIM        = 32;
  localparam int MAX_CELLS      = MAX_DIM * MAX_DIM;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int PHASE_CELLS    = 135;
  localparam int PHASE_SEARCHES = 15;

  typedef enum logic {ROW_CELL, ROW_CFG} plan_kind_e;

  typedef struct packed {
    plan_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic                 open_b;
    logic                 last_b;
    logic                 typed;
    logic                 want;
  } plan_row_t;

  // kind, register, value, row, col, open, last, typed, expected
  localparam plan_row_t PLAN [30] = '{
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b1, 1'b1, 1'b1, 1'b1}, // 1x1 after reset
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0}, // zero rows
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd31, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd1,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_NUM_COLS, 6'd0,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0}, // zero columns
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd31, 1'b1, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG,  CFG_NUM_COLS, 6'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd1,  1'b1, 1'b1, 1'b1, 1'b1}, // open 1x2
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd1,  1'b0, 1'b1, 1'b1, 1'b0},
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_NUM_COLS, 6'd1,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd1,  5'd0,  1'b1, 1'b1, 1'b1, 1'b1}, // open 2x1
    '{ROW_CFG,  CFG_NUM_COLS, 6'd2,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd1,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd1,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd1,  5'd1,  1'b1, 1'b1, 1'b1, 1'b0}, // both ways shut
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd2,  5'd0,  1'b1, 1'b0, 1'b0, 1'b0}, // outside in use
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd2,  1'b1, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd1,  1'b1, 1'b1, 1'b1, 1'b1},
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd63, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0}, // saturate sizes
    '{ROW_CFG,  CFG_NUM_COLS, 6'd63, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd31, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0}, // end walled
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd32, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CFG,  CFG_NUM_COLS, 6'd32, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd31, 5'd31, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b0, 1'b1, 1'b1, 1'b0}, // start walled
    '{ROW_CFG,  CFG_NUM_ROWS, 6'd33, 5'd0,  5'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{ROW_CELL, CFG_NUM_ROWS, 6'd0,  5'd0,  5'd0,  1'b1, 1'b1, 1'b0, 1'b0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;

  // Own copy of the maze and size registers
  logic                 maze_open [MAX_CELLS];
  logic [CFG_W-1:0]     cfg_rows = DIM_RESET;
  logic [CFG_W-1:0]     cfg_cols = DIM_RESET;
  logic                 reach_q [$];

  int src_idle_pct     = 35;
  int snk_idle_pct     = 56;
  int cells_sent       = 0;
  int searches_started = 0;
  int mismatches       = 0;
  int hold_left        = 0;
  int quiet_cycles     = 0;
  bit hold_start       = 1'b0;
  logic want_reach;

  grid_maze_reachability #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Depth-first search from the top-left cell over the open cells in use
  function automatic logic predict_reach();
    int   rows, cols, depth, cur, r, c, nr, nc;
    int   stack_cells [MAX_CELLS];
    logic seen [MAX_CELLS];
    rows = (cfg_rows > MAX_DIM) ? MAX_DIM : int'(cfg_rows);
    cols = (cfg_cols > MAX_DIM) ? MAX_DIM : int'(cfg_cols);
    if (rows == 0 || cols == 0 || !maze_open[0]) return 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[0] = 1'b1;
    stack_cells[0] = 0;
    depth = 1;
    while (depth > 0) begin
      depth--;
      cur = stack_cells[depth];
      r = cur / MAX_DIM;
      c = cur % MAX_DIM;
      if (r == rows - 1 && c == cols - 1) return 1'b1;
      for (int k = 0; k < 4; k++) begin
        nr = r;
        nc = c;
        case (dir_e'(k))
          DIR_LEFT:  nc = c - 1;
          DIR_DOWN:  nr = r + 1;
          DIR_RIGHT: nc = c + 1;
          default:   nr = r - 1;
        endcase
        if (nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
          if (maze_open[nr * MAX_DIM + nc] && !seen[nr * MAX_DIM + nc]) begin
            seen[nr * MAX_DIM + nc] = 1'b1;
            stack_cells[depth] = nr * MAX_DIM + nc;
            depth++;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Offer one cell; on transfer update the maze copy, and on tlast queue the search outcome
  task automatic send_cell(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                           input logic open_b, input logic last_b,
                           input logic typed, input logic want);
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, open_b, c, r};
    s_axis_tlast  = last_b;
    do @(posedge clk_i); while (!s_axis_tready);
    maze_open[r * MAX_DIM + c] = open_b;
    cells_sent++;
    if (last_b) begin
      reach_q.push_back(typed ? want : predict_reach());
      searches_started++;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Write a size register once every pending search has reported
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    while (reach_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_NUM_ROWS) cfg_rows = val;
    else cfg_cols = val;
  endtask

  task automatic set_size(input int rows, input int cols);
    if (cfg_rows != CFG_W'(rows)) write_reg(CFG_NUM_ROWS, CFG_W'(rows));
    if (cfg_cols != CFG_W'(cols)) write_reg(CFG_NUM_COLS, CFG_W'(cols));
  endtask

  // A few scattered cells, the last one starting a search over the current sizes
  task automatic send_touch(input int n);
    for (int i = 0; i < n; i++) begin
      send_cell(COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
                $urandom_range(0, 99) < 65, i == n - 1, 1'b0, 1'b0);
    end
  endtask

  // A complete small maze in raster order, sometimes with a carved monotone path
  task automatic send_maze();
    int   rows, cols, p, r, c;
    logic region [MAX_CELLS];
    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    cols = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    set_size(rows, cols);
    p = $urandom_range(45, 95);
    for (int i = 0; i < rows * MAX_DIM; i++) region[i] = $urandom_range(0, 99) < p;
    if ($urandom_range(0, 99) < 85) begin
      region[0] = 1'b1;
      region[(rows - 1) * MAX_DIM + cols - 1] = 1'b1;
    end
    if ($urandom_range(0, 1) == 1) begin
      r = 0;
      c = 0;
      region[0] = 1'b1;
      while (r < rows - 1 || c < cols - 1) begin
        if (r == rows - 1) c++;
        else if (c == cols - 1) r++;
        else if ($urandom_range(0, 1) == 1) r++;
        else c++;
        region[r * MAX_DIM + c] = 1'b1;
      end
    end
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        send_cell(COORD_W'(i), COORD_W'(j), region[i * MAX_DIM + j],
                  i == rows - 1 && j == cols - 1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic send_random_case();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_maze();
    end else if (pick < 85) begin
      send_touch($urandom_range(1, 4));
    end else if (pick < 95) begin
      // zero or oversized dimensions
      set_size(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(33, 63),
               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 63));
      send_touch($urandom_range(1, 3));
    end else begin
      set_size(($urandom_range(0, 1) == 1) ? 32 : 63, ($urandom_range(0, 1) == 1) ? 32 : 63);
      send_touch($urandom_range(1, 3));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_left  = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = $urandom_range(0, 99) >= snk_idle_pct;
      end
    end
  end

  task automatic report_mismatch(input logic want, input logic got, input bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan) $display("result %0d arrived with no search pending", got);
      else $display("reachable mismatch: expected %0d, got %0d", want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reach_q.size() == 0) begin
        report_mismatch(1'b0, m_axis_tdata[0], 1'b1);
      end else begin
        want_reach = reach_q.pop_front();
        if (m_axis_tdata[0] !== want_reach) report_mismatch(want_reach, m_axis_tdata[0], 1'b0);
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int phase_cells, phase_searches;
    foreach (maze_open[i]) maze_open[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Preload every cell so that no search touches an unwritten one
    for (int i = 0; i < MAX_CELLS; i++) begin
      send_cell(COORD_W'(i / MAX_DIM), COORD_W'(i % MAX_DIM), $urandom_range(0, 99) < 60,
                1'b0, 1'b0, 1'b0);
    end

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
      end else begin
        send_cell(PLAN[i].row, PLAN[i].col, PLAN[i].open_b, PLAN[i].last_b,
                  PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = (ph == 0) ? 35 : (ph == 1) ? 56 : 0;
      snk_idle_pct   = (ph == 0) ? 56 : (ph == 1) ? 35 : 0;
      phase_cells    = cells_sent;
      phase_searches = searches_started;
      if (ph == 2) begin
        // hold the output while searches pile up behind it
        hold_start = 1'b1;
        repeat (4) send_touch($urandom_range(1, 3));
      end
      while (cells_sent - phase_cells < PHASE_CELLS ||
             searches_started - phase_searches < PHASE_SEARCHES) begin
        send_random_case();
      end
    end

    while (reach_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
